// ===== hdl/repeating_stereo_delay_defines.svh =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef REPEATING_STEREO_DELAY_DEFINES_SVH
`define REPEATING_STEREO_DELAY_DEFINES_SVH

`ifndef SYNTH

// property holds at every clock edge out of reset
`define RSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("repeating_stereo_delay check failed");

// trigger implies consequence in the next cycle
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("repeating_stereo_delay sequence check failed");

`else

`define RSD_ASSERT(lbl, clk, rst_n, prop)
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

// ===== hdl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - package
// Shared constants, types and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

    localparam int BUF_DEPTH  = 65536;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int PLAY_W     = 16;
    localparam int CMP_W      = (ADDR_W > PLAY_W) ? ADDR_W : PLAY_W;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int REP_W      = 5;
    localparam int PROD_W     = 34;
    localparam int SCALED_W   = 18;
    localparam int SUM_W      = 19;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [GAIN_W-1:0] GAIN_ONE        = 17'd65536;
    localparam logic [GAIN_W-1:0] WET_RESET       = 17'd32768;
    localparam logic [GAIN_W-1:0] DECAY_RESET     = 17'd49152;
    localparam logic [REP_W-1:0]  REPEAT_RESET    = 5'd1;
    localparam logic [PLAY_W-1:0] PLAYBACK_RESET  = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WET,
        REG_DECAY,
        REG_REPEAT,
        REG_PLAYBACK
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_WRITE,
        S_SUM
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic wr;
    } step_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [GAIN_W-1:0] wet;
        logic [GAIN_W-1:0] dry;
        logic [GAIN_W-1:0] amp;
        logic              hit;
        logic              rd_ok;
        logic              active;
    } lane_ctl_t;

    // product / 65536, truncated toward zero
    function automatic logic signed [SCALED_W-1:0] qscale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? (p + 34'sd65535) : p;
        return adj[PROD_W-1:16];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767)
            r = 16'sh7FFF;
        else if (v < -19'sd32768)
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [CFG_DATA_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] x);
        return (x == ADDR_W'(BUF_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/repeating_stereo_delay.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - top level
// Stereo delay with decaying repeats; one left/right lane each plus merge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: left_in/right_in with in_valid, accepted when in_stall low.
//   Output channel: left_out/right_out with out_valid; the receiver holds
//   out_stall high to keep the current item.
//   Config channel: cfg_index/cfg_data with cfg_valid/cfg_ready; index 0 wet
//   gain, 1 decay gain, 2 repeat limit, 3 playback limit. A write to these
//   restarts positions, repeat count and amplitude; the delay stores are kept.
//   Flow: an accepted item runs the four-step sequence (read, multiply, store
//   write with forward, sum) on each lane's store and is loaded into the output
//   register when it is free; the next item is taken only after that load.
//   The output register frees the input side: the next item is taken while a
//   finished result waits under out_stall; a full output register holds the
//   lanes in their last step until it drains.
//   Reset: registers take their defaults and delay stores read as zero until
//   written, tracked by a fill count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "repeating_stereo_delay_defines.svh"

module repeating_stereo_delay (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_stall,
    input  wire logic signed [rsd_pkg::SAMPLE_W-1:0]  left_in,
    input  wire logic signed [rsd_pkg::SAMPLE_W-1:0]  right_in,
    output      logic                                 out_valid,
    input  wire logic                                 out_stall,
    output      logic signed [rsd_pkg::SAMPLE_W-1:0]  left_out,
    output      logic signed [rsd_pkg::SAMPLE_W-1:0]  right_out,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [rsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import rsd_pkg::*;

    state_t state_reg, state_next;
    step_t  step;
    logic   load;
    logic   out_free;
    logic   cfg_we;

    lane_ctl_t                  lane_ctl;
    logic signed [SAMPLE_W-1:0] left_mix;
    logic signed [SAMPLE_W-1:0] right_mix;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_W-1:0] right_out_reg, right_out_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_we   = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cfg_ready   = 1'b0;
        step.accept = 1'b0;
        step.mul    = 1'b0;
        step.wr     = 1'b0;
        load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = cfg_valid;
                cfg_ready   = 1'b1;
                step.accept = in_valid && !cfg_valid;
            end
            S_MUL:
            begin
                step.mul = 1'b1;
            end
            S_WRITE:
            begin
                step.wr = 1'b1;
            end
            S_SUM:
            begin
                load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    rsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lane_ctl  (lane_ctl)
    );

    rsd_lane u_lane_left (
        .clk      (clk),
        .step     (step),
        .lane_ctl (lane_ctl),
        .sample   (left_in),
        .mix      (left_mix)
    );

    rsd_lane u_lane_right (
        .clk      (clk),
        .step     (step),
        .lane_ctl (lane_ctl),
        .sample   (right_in),
        .mix      (right_mix)
    );

    // merge: both lanes land in one output item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            left_out_next  = left_mix;
            right_out_next = right_mix;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    `RSD_ASSERT_NEXT(a_accept_to_mul, clk, rst_n, step.accept, state_reg == S_MUL)
    `RSD_ASSERT_NEXT(a_load_gives_item, clk, rst_n, load, out_valid_reg)
    `RSD_ASSERT(a_no_cfg_while_busy, clk, rst_n, !(cfg_we && (state_reg != S_IDLE)))

endmodule

`default_nettype wire

// ===== hdl/rsd_ram.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/rsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - control
// Register file, write/read positions, repeat count, amplitude and fill count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "repeating_stereo_delay_defines.svh"

module rsd_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rsd_pkg::step_t                step,
    input  wire logic                          cfg_we,
    input  wire logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output      rsd_pkg::lane_ctl_t            lane_ctl
);

    import rsd_pkg::*;

    logic [GAIN_W-1:0] wet_reg, wet_next;
    logic [GAIN_W-1:0] decay_reg, decay_next;
    logic [REP_W-1:0]  rep_lim_reg, rep_lim_next;
    logic [PLAY_W-1:0] play_reg, play_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rpos_reg, rpos_next;
    logic [REP_W-1:0]  reps_reg, reps_next;
    logic [GAIN_W-1:0] amp_reg, amp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic              hit_reg, hit_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              active_reg, active_next;
    logic              loop_reg, loop_next;
    logic [PROD_W-1:0] amp_prod_reg, amp_prod_next;

    logic              active;
    logic              do_loop;
    logic [ADDR_W-1:0] rp;
    logic              reload;

    assign active  = (reps_reg != '0);
    assign do_loop = active && (CMP_W'(rpos_reg) > CMP_W'(play_reg));
    assign rp      = do_loop ? '0 : rpos_reg;

    always_comb
    begin
        wet_next      = wet_reg;
        decay_next    = decay_reg;
        rep_lim_next  = rep_lim_reg;
        play_next     = play_reg;
        wp_next       = wp_reg;
        rpos_next     = rpos_reg;
        reps_next     = reps_reg;
        amp_next      = amp_reg;
        fill_next     = fill_reg;
        wa_next       = wa_reg;
        hit_next      = hit_reg;
        rd_ok_next    = rd_ok_reg;
        active_next   = active_reg;
        loop_next     = loop_reg;
        amp_prod_next = amp_prod_reg;
        reload        = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WET:
                begin
                    wet_next = clamp_gain(cfg_data);
                    reload   = 1'b1;
                end
                REG_DECAY:
                begin
                    decay_next = clamp_gain(cfg_data);
                    reload     = 1'b1;
                end
                REG_REPEAT:
                begin
                    rep_lim_next = cfg_data[REP_W-1:0];
                    reload       = 1'b1;
                end
                REG_PLAYBACK:
                begin
                    play_next = cfg_data[PLAY_W-1:0];
                    reload    = 1'b1;
                end
                default:
                begin
                    reload = 1'b0;
                end
            endcase
        end

        if (reload)
        begin
            wp_next   = '0;
            rpos_next = '0;
            reps_next = rep_lim_next;
            amp_next  = decay_next;
        end
        else if (step.accept)
        begin
            wa_next       = wp_reg;
            hit_next      = (rp == wp_reg);
            rd_ok_next    = (FILL_W'(rp) < fill_reg);
            active_next   = active;
            loop_next     = do_loop;
            amp_prod_next = PROD_W'(amp_reg) * PROD_W'(decay_reg);
            reps_next     = do_loop ? reps_reg - 1'b1 : reps_reg;
            wp_next       = wrap_inc(wp_reg);
            rpos_next     = wrap_inc(rp);
        end
        else if (step.mul)
        begin
            if (loop_reg)
            begin
                amp_next = amp_prod_reg[32:16];
            end
        end
        else if (step.wr)
        begin
            if (FILL_W'(wa_reg) == fill_reg)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_reg     <= WET_RESET;
            decay_reg   <= DECAY_RESET;
            rep_lim_reg <= REPEAT_RESET;
            play_reg    <= PLAYBACK_RESET;
            wp_reg      <= '0;
            rpos_reg    <= '0;
            reps_reg    <= REPEAT_RESET;
            amp_reg     <= DECAY_RESET;
            fill_reg    <= '0;
            hit_reg     <= 1'b0;
            rd_ok_reg   <= 1'b0;
            active_reg  <= 1'b0;
            loop_reg    <= 1'b0;
        end
        else
        begin
            wet_reg     <= wet_next;
            decay_reg   <= decay_next;
            rep_lim_reg <= rep_lim_next;
            play_reg    <= play_next;
            wp_reg      <= wp_next;
            rpos_reg    <= rpos_next;
            reps_reg    <= reps_next;
            amp_reg     <= amp_next;
            fill_reg    <= fill_next;
            hit_reg     <= hit_next;
            rd_ok_reg   <= rd_ok_next;
            active_reg  <= active_next;
            loop_reg    <= loop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg       <= wa_next;
        amp_prod_reg <= amp_prod_next;
    end

    always_comb
    begin
        lane_ctl.rd_addr = rp;
        lane_ctl.wr_addr = wa_reg;
        lane_ctl.wet     = wet_reg;
        lane_ctl.dry     = GAIN_ONE - wet_reg;
        lane_ctl.amp     = amp_reg;
        lane_ctl.hit     = hit_reg;
        lane_ctl.rd_ok   = rd_ok_reg;
        lane_ctl.active  = active_reg;
    end

    `RSD_ASSERT(a_reps_in_limit, clk, rst_n, reps_reg <= rep_lim_reg)
    `RSD_ASSERT(a_amp_in_range, clk, rst_n, amp_reg <= GAIN_ONE)
    `RSD_ASSERT(a_fill_in_range, clk, rst_n, fill_reg <= FILL_W'(BUF_DEPTH))
    `RSD_ASSERT_NEXT(a_loop_uses_repeat, clk, rst_n, step.accept && do_loop && !cfg_we,
                     reps_reg == $past(reps_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== hdl/rsd_lane.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - channel lane
// Delay store, wet/dry scaling and delayed-sample mix for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_lane (
    input  wire logic                                clk,
    input  wire rsd_pkg::step_t                      step,
    input  wire rsd_pkg::lane_ctl_t                  lane_ctl,
    input  wire logic signed [rsd_pkg::SAMPLE_W-1:0] sample,
    output      logic signed [rsd_pkg::SAMPLE_W-1:0] mix
);

    import rsd_pkg::*;

    logic signed [SAMPLE_W-1:0] s_reg, s_next;
    logic signed [PROD_W-1:0]   wet_prod_reg, wet_prod_next;
    logic signed [PROD_W-1:0]   dry_prod_reg, dry_prod_next;
    logic signed [SAMPLE_W-1:0] rd_reg, rd_next;
    logic signed [PROD_W-1:0]   dly_prod_reg, dly_prod_next;
    logic signed [SCALED_W-1:0] dry_reg, dry_next;

    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SCALED_W-1:0] wet_q;
    logic signed [SAMPLE_W-1:0] wet_val;
    logic signed [SAMPLE_W-1:0] dly_sample;
    logic signed [SCALED_W-1:0] dly_q;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SCALED_W-1:0] wet_s;
    logic signed [SCALED_W-1:0] dry_s;
    logic signed [SCALED_W-1:0] amp_s;

    assign wet_s = {1'b0, lane_ctl.wet};
    assign dry_s = {1'b0, lane_ctl.dry};
    assign amp_s = {1'b0, lane_ctl.amp};

    rsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (step.wr),
        .waddr (lane_ctl.wr_addr),
        .wdata (wet_val),
        .re    (step.accept),
        .raddr (lane_ctl.rd_addr),
        .rdata (rdata)
    );

    assign wet_q      = qscale(wet_prod_reg);
    assign wet_val    = sat16({wet_q[SCALED_W-1], wet_q});
    assign dly_sample = lane_ctl.hit ? wet_val : rd_reg;
    assign dly_q      = lane_ctl.active ? qscale(dly_prod_reg) : '0;
    assign sum        = {dry_reg[SCALED_W-1], dry_reg} + {dly_q[SCALED_W-1], dly_q};
    assign mix        = sat16(sum);

    always_comb
    begin
        s_next        = step.accept ? sample : s_reg;
        wet_prod_next = wet_prod_reg;
        dry_prod_next = dry_prod_reg;
        rd_next       = rd_reg;
        dly_prod_next = dly_prod_reg;
        dry_next      = dry_reg;
        if (step.mul)
        begin
            wet_prod_next = s_reg * wet_s;
            dry_prod_next = s_reg * dry_s;
            rd_next       = lane_ctl.rd_ok ? $signed(rdata) : '0;
        end
        if (step.wr)
        begin
            dly_prod_next = dly_sample * amp_s;
            dry_next      = qscale(dry_prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        wet_prod_reg <= wet_prod_next;
        dry_prod_reg <= dry_prod_next;
        rd_reg       <= rd_next;
        dly_prod_reg <= dly_prod_next;
        dry_reg      <= dry_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Repeating stereo delay - testbench
// Drives stereo items with random gaps and output stalls, rewrites the gain,
// repeat and playback registers between idle phases, and checks every output
// item against a cycle-free predictor of the delay stores and repeat state.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REG_SPARE_FIRST = int'(REG_PLAYBACK) + 1;
    localparam int REG_SPARE_LAST  = (1 << CFG_IDX_W) - 1;
    localparam int DATA_MAX        = (1 << CFG_DATA_W) - 1;
    localparam int DECAY_FLOOR     = 655;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left_mix;
        sample_t right_mix;
    } mix_t;

    class stereo_echo_sb;
        sample_t     left_store [BUF_DEPTH];
        sample_t     right_store [BUF_DEPTH];
        int unsigned wet_reg, decay_reg, repeat_reg, playback_reg;
        int unsigned write_pos, read_pos, repeats_left, amp_factor;
        mix_t        pending_mix [$];
        int          errors;

        function new();
            foreach (left_store[i]) left_store[i] = '0;
            foreach (right_store[i]) right_store[i] = '0;
            wet_reg      = WET_RESET;
            decay_reg    = DECAY_RESET;
            repeat_reg   = REPEAT_RESET;
            playback_reg = PLAYBACK_RESET;
            errors       = 0;
            restart();
        endfunction

        function int unsigned unity_cap(int unsigned g);
            return (g > GAIN_ONE) ? GAIN_ONE : g;
        endfunction

        function longint gain_part(longint s, longint g);
            return (s * g) / longint'(GAIN_ONE);
        endfunction

        function sample_t clip16(longint v);
            if (v > 32767)
                return SAMPLE_MAX;
            if (v < -32768)
                return SAMPLE_MIN;
            return sample_t'(v);
        endfunction

        function void restart();
            write_pos    = 0;
            read_pos     = 0;
            repeats_left = repeat_reg;
            amp_factor   = unity_cap(decay_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_WET:      wet_reg = val;
                REG_DECAY:    decay_reg = val;
                REG_REPEAT:   repeat_reg = val[REP_W-1:0];
                REG_PLAYBACK: playback_reg = val[PLAY_W-1:0];
                default:      return;
            endcase
            restart();
        endfunction

        function void note_pair(sample_t l, sample_t r);
            int unsigned wet, dry;
            longint      lo, ro;
            mix_t        m;
            wet = unity_cap(wet_reg);
            dry = GAIN_ONE - wet;
            lo  = gain_part(l, dry);
            ro  = gain_part(r, dry);
            left_store[write_pos]  = clip16(gain_part(l, wet));
            right_store[write_pos] = clip16(gain_part(r, wet));
            if (repeats_left > 0)
            begin
                if (read_pos > playback_reg)
                begin
                    read_pos     = 0;
                    repeats_left = repeats_left - 1;
                    amp_factor   = int'((longint'(amp_factor)
                                   * longint'(unity_cap(decay_reg))) >> 16);
                end
                lo += gain_part(left_store[read_pos], amp_factor);
                ro += gain_part(right_store[read_pos], amp_factor);
            end
            m.left_mix  = clip16(lo);
            m.right_mix = clip16(ro);
            pending_mix.push_back(m);
            write_pos = (write_pos + 1) % BUF_DEPTH;
            read_pos  = (read_pos + 1) % BUF_DEPTH;
        endfunction

        function void check_pair(sample_t l, sample_t r);
            mix_t m;
            if (pending_mix.size() == 0)
            begin
                $error("output item with nothing expected: left_out %0d right_out %0d", l, r);
                errors++;
                return;
            end
            m = pending_mix.pop_front();
            if (l !== m.left_mix)
            begin
                $error("left_out: expected %0d, got %0d", m.left_mix, l);
                errors++;
            end
            if (r !== m.right_mix)
            begin
                $error("right_out: expected %0d, got %0d", m.right_mix, r);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    sample_t                left_in = '0;
    sample_t                right_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    sample_t                left_out;
    sample_t                right_out;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    stereo_echo_sb sb = new();

    int  cycles = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  stall_count = 0;
    bit  rx_calm = 1'b0;
    bit  tx_calm = 1'b0;

    repeating_stereo_delay dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // output side: random stalls plus long holds on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pair(left_out, right_out);
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            stall_count = HOLD_CYCLES;
        end
        else if (stall_count > 0)
            stall_count--;
        else if (!rx_calm && $urandom_range(0, 3) == 0)
            stall_count = pick_gap();
        out_stall <= (stall_count > 0);
    end

    task automatic send_pair(input sample_t l, input sample_t r);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do @(posedge clk); while (in_stall);
        sb.note_pair(l, r);
    endtask

    // leave the block idle with every output item received
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_mix.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return sample_t'($urandom_range(0, 512)) - 16'sd256;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_ONE;
            2:       return $urandom_range(int'(GAIN_ONE) + 1, DATA_MAX);
            3:       return DECAY_FLOOR;
            default: return $urandom_range(DECAY_FLOOR, int'(GAIN_ONE));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_repeats();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return (1 << REP_W) - 1;
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_playback();
        case ($urandom_range(0, 19))
            0:       return (1 << PLAY_W) - 1;
            1:       return (1 << PLAY_W) - 2;
            2:       return $urandom_range(0, (1 << PLAY_W) - 1);
            3, 4:    return $urandom_range(41, 400);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic random_setting();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1:    write_reg(REG_WET, pick_gain());
                2, 3:    write_reg(REG_DECAY, pick_gain());
                4, 5:    write_reg(REG_REPEAT, pick_repeats());
                6, 7, 8: write_reg(REG_PLAYBACK, pick_playback());
                default: write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                                   CFG_DATA_W'($urandom));
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int batch;
        int phase;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: read and write share an index
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair('0, '0);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'shAAAA, 16'sh5555);
        settle();

        // gains above one, short loop with a few repeats
        write_reg(REG_WET, DATA_MAX);
        write_reg(REG_DECAY, DATA_MAX);
        write_reg(REG_REPEAT, 2);
        write_reg(REG_PLAYBACK, 1);
        cfg_valid <= 1'b0;
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(16'sd100, -16'sd100);
        send_pair(16'sd1, 16'sd1);
        send_pair(-16'sd1, -16'sd1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        settle();

        // no repeats at all: dry part only
        write_reg(REG_REPEAT, 0);
        write_reg(REG_WET, GAIN_ONE);
        cfg_valid <= 1'b0;
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(-16'sd12345, 16'sd12345);
        settle();

        // limit at the last store index, decay gain at its floor
        write_reg(REG_REPEAT, (1 << REP_W) - 1);
        write_reg(REG_PLAYBACK, (1 << PLAY_W) - 1);
        write_reg(REG_WET, 40000);
        write_reg(REG_DECAY, DECAY_FLOOR);
        cfg_valid <= 1'b0;
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, 16'sd0);
        send_pair(16'sd7, -16'sd7);
        settle();

        // unknown index must leave positions running
        write_reg(CFG_IDX_W'(REG_SPARE_FIRST), DATA_MAX);
        cfg_valid <= 1'b0;
        send_pair(16'sd300, -16'sd300);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        settle();

        write_reg(REG_WET, 0);
        write_reg(REG_DECAY, 0);
        write_reg(REG_PLAYBACK, 0);
        cfg_valid <= 1'b0;
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(16'sd2, -16'sd3);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            random_setting();
            batch = $urandom_range(20, 120);
            if (phase == 3)
            begin
                // receiver holds off while the sender keeps offering
                tx_calm = 1'b1;
                hold_requests <= hold_requests + 1;
                batch = 60;
            end
            else if (phase == 6)
            begin
                tx_calm = 1'b1;
                rx_calm <= 1'b1;
            end
            repeat (batch) send_pair(pick_sample(), pick_sample());
            sent += batch;
            settle();
            tx_calm = 1'b0;
            rx_calm <= 1'b0;
            phase++;
        end

        if (sb.errors == 0 && sb.pending_mix.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/rsd_pkg.sv
hdl/rsd_ram.sv
hdl/rsd_ctrl.sv
hdl/rsd_lane.sv
hdl/repeating_stereo_delay.sv
tb/tb.sv
